[sv/kol_pkg.sv]
package kol_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int OPC_W  = 3;
	localparam int KEY_W  = 16;
	localparam int VAL_W  = 32;
	localparam int STS_W  = 2;
	localparam int OCNT_W = 5;

	typedef logic [KEY_W-1:0]        key_t;
	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [CNT_W-1:0]        cnt_t;

	typedef enum logic [OPC_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_FIND       = 3'd3,
		OP_DELETE     = 3'd4
	} op_t;

	typedef enum logic [STS_W-1:0] {
		STATUS_OK   = 2'd0,
		STATUS_MISS = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PUSH_FRONT,
		CELL_PUSH_BACK,
		CELL_REMOVE
	} cell_op_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		cell_op_t op;
		key_t     key;
		val_t     value;
		idx_t     pos;
		cnt_t     count;
	} cell_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

endpackage

[sv/kol_req_if.sv]
interface kol_req_if;
	import kol_pkg::*;

	logic             valid;
	logic             ready;
	logic [OPC_W-1:0] opcode;
	key_t             key;
	val_t             value;

	modport source (output valid, output opcode, output key, output value, input ready);
	modport sink (input valid, input opcode, input key, input value, output ready);

endinterface

[sv/kol_rsp_if.sv]
interface kol_rsp_if;
	import kol_pkg::*;

	logic              valid;
	logic              ready;
	logic [STS_W-1:0]  status;
	key_t              entry_key;
	val_t              entry_value;
	logic [OCNT_W-1:0] count;

	modport source (output valid, output status, output entry_key, output entry_value,
		output count, input ready);
	modport sink (input valid, input status, input entry_key, input entry_value,
		input count, output ready);

endinterface

[sv/keyed_ordered_list_unit.sv]
// Insert front/back, pop front and unused opcodes: result registered on accept.
// Find/delete: the scan visits one cell per cycle from the front; the result is registered
// at the first hit, or as a miss after the last occupied cell.
// A new transaction is taken in the cycle its predecessor's result is accepted, so inserts
// and pops sustain one per cycle unless stalled; the scan sets the find/delete occupancy.
// Reset clears the entry count, the scan control and the result valid; cell data is not reset.
module keyed_ordered_list_unit (
	input logic       clk,
	input logic       arst_n,
	kol_req_if.sink   req,
	kol_rsp_if.source rsp
);
	import kol_pkg::*;

	state_t    state_q, state_d;
	cnt_t      count_q, count_d;
	idx_t      ptr_q;
	key_t      key_q;
	logic      del_q;
	cell_cmd_t cmd;

	key_t             keys   [DEPTH];
	val_t             values [DEPTH];
	logic [DEPTH-1:0] hits;

	logic    req_fire, out_free;
	logic    in_range, last, found, scan_done;
	logic    load_res;
	status_t res_status;
	key_t    res_key;
	val_t    res_value;

	logic              out_valid_q;
	status_t           status_q;
	key_t              entry_key_q;
	val_t              entry_value_q;
	logic [OCNT_W-1:0] count_out_q;

	kol_cell_array u_cells (
		.clk    (clk),
		.cmd    (cmd),
		.keys   (keys),
		.values (values),
		.hits   (hits)
	);

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign req_fire  = req.valid && req.ready;

	assign in_range  = cnt_t'(ptr_q) < count_q;
	assign last      = (cnt_t'(ptr_q) + cnt_t'(1)) >= count_q;
	assign found     = in_range && hits[ptr_q];
	assign scan_done = found || !in_range || last;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire && (op_t'(req.opcode) == OP_FIND ||
						op_t'(req.opcode) == OP_DELETE)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op     = CELL_HOLD;
		cmd.key    = (state_q == ST_SCAN) ? key_q : req.key;
		cmd.value  = req.value;
		cmd.pos    = '0;
		cmd.count  = count_q;
		count_d    = count_q;
		load_res   = 1'b0;
		res_status = STATUS_MISS;
		res_key    = '0;
		res_value  = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					case (op_t'(req.opcode))
						OP_PUSH_FRONT, OP_PUSH_BACK: begin
							load_res = 1'b1;
							if (count_q == cnt_t'(DEPTH)) begin
								res_status = STATUS_FULL;
							end else begin
								res_status = STATUS_OK;
								cmd.op     = (op_t'(req.opcode) == OP_PUSH_FRONT) ?
									CELL_PUSH_FRONT : CELL_PUSH_BACK;
								count_d    = count_q + cnt_t'(1);
							end
						end
						OP_POP_FRONT: begin
							load_res = 1'b1;
							if (count_q != '0) begin
								res_status = STATUS_OK;
								res_key    = keys[0];
								res_value  = values[0];
								cmd.op     = CELL_REMOVE;
								count_d    = count_q - cnt_t'(1);
							end
						end
						OP_FIND, OP_DELETE: begin
						end
						default: load_res = 1'b1;
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					load_res = 1'b1;
					if (found) begin
						res_status = STATUS_OK;
						res_key    = keys[ptr_q];
						res_value  = values[ptr_q];
						if (del_q) begin
							cmd.op  = CELL_REMOVE;
							cmd.pos = ptr_q;
							count_d = count_q - cnt_t'(1);
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			del_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (req_fire) begin
				ptr_q <= '0;
				del_q <= (op_t'(req.opcode) == OP_DELETE);
			end else if (state_q == ST_SCAN && !scan_done) begin
				ptr_q <= ptr_q + idx_t'(1);
			end
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			key_q <= req.key;
		end
		if (load_res) begin
			status_q      <= res_status;
			entry_key_q   <= res_key;
			entry_value_q <= res_value;
			count_out_q   <= OCNT_W'(count_d);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.entry_key   = entry_key_q;
	assign rsp.entry_value = entry_value_q;
	assign rsp.count       = count_out_q;

endmodule

[sv/kol_cell.sv]
module kol_cell (
	input  logic              clk,
	input  kol_pkg::idx_t     idx,
	input  kol_pkg::cell_cmd_t cmd,
	input  kol_pkg::key_t     left_key,
	input  kol_pkg::val_t     left_value,
	input  kol_pkg::key_t     right_key,
	input  kol_pkg::val_t     right_value,
	output kol_pkg::key_t     key,
	output kol_pkg::val_t     value,
	output logic              hit
);
	import kol_pkg::*;

	key_t key_q, key_d;
	val_t value_q, value_d;
	logic occupied;

	assign occupied = cnt_t'(idx) < cmd.count;
	assign hit      = occupied && (key_q == cmd.key);
	assign key      = key_q;
	assign value    = value_q;

	always_comb begin
		key_d   = key_q;
		value_d = value_q;
		case (cmd.op)
			CELL_PUSH_FRONT: begin
				if (idx == '0) begin
					key_d   = cmd.key;
					value_d = cmd.value;
				end else begin
					key_d   = left_key;
					value_d = left_value;
				end
			end
			CELL_PUSH_BACK: begin
				// first free slot takes the new entry
				if (cnt_t'(idx) == cmd.count) begin
					key_d   = cmd.key;
					value_d = cmd.value;
				end
			end
			CELL_REMOVE: begin
				// close the gap from the removed position onward
				if (idx >= cmd.pos) begin
					key_d   = right_key;
					value_d = right_value;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		key_q   <= key_d;
		value_q <= value_d;
	end

endmodule

[sv/kol_cell_array.sv]
module kol_cell_array (
	input  logic               clk,
	input  kol_pkg::cell_cmd_t cmd,
	output kol_pkg::key_t      keys   [kol_pkg::DEPTH],
	output kol_pkg::val_t      values [kol_pkg::DEPTH],
	output logic [kol_pkg::DEPTH-1:0] hits
);
	import kol_pkg::*;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		key_t lk, rk;
		val_t lv, rv;

		if (i == 0) begin : g_first
			assign lk = cmd.key;
			assign lv = cmd.value;
		end else begin : g_left
			assign lk = keys[i-1];
			assign lv = values[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign rk = keys[i];
			assign rv = values[i];
		end else begin : g_right
			assign rk = keys[i+1];
			assign rv = values[i+1];
		end

		kol_cell u_cell (
			.clk         (clk),
			.idx         (idx_t'(i)),
			.cmd         (cmd),
			.left_key    (lk),
			.left_value  (lv),
			.right_key   (rk),
			.right_value (rv),
			.key         (keys[i]),
			.value       (values[i]),
			.hit         (hits[i])
		);
	end

endmodule

[sv/kol_checker.sv]
module kol_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [kol_pkg::STS_W-1:0]   rsp_status,
	input kol_pkg::key_t               rsp_entry_key,
	input kol_pkg::val_t               rsp_entry_value,
	input logic [kol_pkg::OCNT_W-1:0]  rsp_count
);
	import kol_pkg::*;

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result valid dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_entry_key) &&
			$stable(rsp_entry_value) && $stable(rsp_count))
		else $error("result payload changed while stalled");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STATUS_FULL |-> rsp_count == OCNT_W'(DEPTH))
		else $error("full refusal with list not full");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != STATUS_OK |-> rsp_entry_key == '0 && rsp_entry_value == '0)
		else $error("entry fields nonzero on refused or missed transaction");

endmodule

bind keyed_ordered_list_unit kol_checker u_kol_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_entry_key   (rsp.entry_key),
	.rsp_entry_value (rsp.entry_value),
	.rsp_count       (rsp.count)
);

[bench/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import kol_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 2 * DEPTH + 20;
	localparam int HOLD_OFF_LEN = 300;
	localparam int IDLE_PCT     = 32;

	localparam logic [OPC_W-1:0] OP_FIRST_UNUSED = OPC_W'(OP_DELETE + 1);
	localparam logic [OPC_W-1:0] OP_LAST_UNUSED  = '1;

	typedef struct {
		status_t           status;
		key_t              entry_key;
		val_t              entry_value;
		logic [OCNT_W-1:0] count;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n;

	kol_req_if req ();
	kol_rsp_if rsp ();

	keyed_ordered_list_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// shadow copy of the list, front at position 0
	key_t model_keys [DEPTH];
	val_t model_values [DEPTH];
	int   model_count = 0;

	list_result_t pending_results [$];
	int           error_count = 0;
	int           quiet_cycles = 0;
	int           hold_off_cycles = 0;
	bit           no_idle = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int find_slot(input key_t k);
		int i;
		for (i = 0; i < model_count; i++)
			if (model_keys[i] == k)
				return i;
		return model_count;
	endfunction

	function automatic void remove_slot(input int pos);
		int i;
		for (i = pos; i + 1 < model_count; i++) begin
			model_keys[i]   = model_keys[i + 1];
			model_values[i] = model_values[i + 1];
		end
		model_count--;
	endfunction

	function automatic list_result_t apply_list_op(input logic [OPC_W-1:0] op, input key_t k,
		input val_t v);
		list_result_t r;
		int           i;
		int           pos;
		r.status      = STATUS_MISS;
		r.entry_key   = '0;
		r.entry_value = '0;
		case (op)
			OP_PUSH_FRONT: begin
				if (model_count >= DEPTH) begin
					r.status = STATUS_FULL;
				end else begin
					for (i = model_count; i > 0; i--) begin
						model_keys[i]   = model_keys[i - 1];
						model_values[i] = model_values[i - 1];
					end
					model_keys[0]   = k;
					model_values[0] = v;
					model_count++;
					r.status = STATUS_OK;
				end
			end
			OP_PUSH_BACK: begin
				if (model_count >= DEPTH) begin
					r.status = STATUS_FULL;
				end else begin
					model_keys[model_count]   = k;
					model_values[model_count] = v;
					model_count++;
					r.status = STATUS_OK;
				end
			end
			OP_POP_FRONT: begin
				if (model_count > 0) begin
					r.entry_key   = model_keys[0];
					r.entry_value = model_values[0];
					remove_slot(0);
					r.status = STATUS_OK;
				end
			end
			OP_FIND, OP_DELETE: begin
				pos = find_slot(k);
				if (pos < model_count) begin
					r.entry_key   = model_keys[pos];
					r.entry_value = model_values[pos];
					if (op == OP_DELETE)
						remove_slot(pos);
					r.status = STATUS_OK;
				end
			end
			default: begin
			end
		endcase
		r.count = OCNT_W'(model_count);
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] want,
		input logic [31:0] got);
		$display("%0t mismatch on %s: expected %h, got %h", $realtime, field, want, got);
		error_count++;
	endtask

	// hold the transaction until the block takes it, then record what it should answer
	task automatic send_request(input logic [OPC_W-1:0] op, input key_t k, input val_t v);
		int gap;
		gap = 0;
		if (!no_idle)
			while ($urandom_range(0, 99) < IDLE_PCT)
				gap++;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid  <= 1'b1;
		req.opcode <= op;
		req.key    <= k;
		req.value  <= v;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		pending_results.push_back(apply_list_op(op, k, v));
	endtask

	function automatic key_t pick_key();
		int roll;
		roll = $urandom_range(0, 99);
		if (model_count > 0 && roll < 60)
			return model_keys[$urandom_range(0, model_count - 1)];
		if (roll < 85)
			return key_t'($urandom_range(0, 15));
		return key_t'($urandom);
	endfunction

	function automatic val_t pick_value();
		case ($urandom_range(0, 19))
			0: return {1'b1, {(VAL_W-1){1'b0}}};
			1: return {1'b0, {(VAL_W-1){1'b1}}};
			2: return '0;
			3: return '1;
			default: return val_t'($urandom);
		endcase
	endfunction

	task automatic test_directed_cases();
		int i;
		// empty list
		send_request(OP_POP_FRONT, 16'h1234, 32'h5555_aaaa);
		send_request(OP_FIND, 16'h0000, '0);
		send_request(OP_DELETE, 16'hffff, '0);
		// insert at the back of an empty list, then at the front
		send_request(OP_PUSH_BACK, 16'h0000, {1'b1, {(VAL_W-1){1'b0}}});
		send_request(OP_PUSH_FRONT, 16'hffff, {1'b0, {(VAL_W-1){1'b1}}});
		for (i = OP_FIRST_UNUSED; i <= OP_LAST_UNUSED; i++)
			send_request(OPC_W'(i), 16'hffff, '1);
		send_request(OP_FIND, 16'hffff, '0);
		send_request(OP_FIND, 16'h8000, '0);
		send_request(OP_DELETE, 16'h7fff, '0);
		// duplicate key: frontmost match wins
		send_request(OP_PUSH_BACK, 16'h0000, '1);
		send_request(OP_FIND, 16'h0000, '0);
		send_request(OP_DELETE, 16'h0000, '0);
		send_request(OP_FIND, 16'h0000, '0);
		// fill, overflow at both ends, then delete the back entry and pop the front
		while (model_count < DEPTH)
			send_request(OP_PUSH_BACK, key_t'(model_count), val_t'($urandom));
		send_request(OP_PUSH_FRONT, 16'haaaa, '1);
		send_request(OP_PUSH_BACK, 16'h5555, '1);
		send_request(OP_DELETE, key_t'(DEPTH - 1), '0);
		send_request(OP_POP_FRONT, '0, '0);
	endtask

	task automatic test_random_mix(input int n_items);
		int               i;
		int               roll;
		int               push_pct;
		logic [OPC_W-1:0] op;
		for (i = 0; i < n_items; i++) begin
			// alternate between filling and draining so the count sweeps its range
			push_pct = ((i / 80) % 2 == 0) ? 60 : 25;
			roll = $urandom_range(0, 99);
			if (roll < push_pct) begin
				op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 30)
					op = OP_POP_FRONT;
				else if (roll < 60)
					op = OP_FIND;
				else if (roll < 95)
					op = OP_DELETE;
				else
					op = OPC_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
			end
			send_request(op, pick_key(), pick_value());
		end
	endtask

	task automatic test_output_hold_off();
		hold_off_cycles = HOLD_OFF_LEN;
		test_random_mix(40);
	endtask

	task automatic test_full_rate();
		no_idle = 1'b1;
		test_random_mix(150);
		no_idle = 1'b0;
	endtask

	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			rsp.ready <= 1'b0;
			hold_off_cycles--;
		end else if (no_idle) begin
			rsp.ready <= 1'b1;
		end else begin
			rsp.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		list_result_t want;
		if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result status", '0, rsp.status);
			end else begin
				want = pending_results.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", want.status, rsp.status);
				if (rsp.entry_key !== want.entry_key)
					report_mismatch("entry_key", want.entry_key, rsp.entry_key);
				if (rsp.entry_value !== want.entry_value)
					report_mismatch("entry_value", want.entry_value, rsp.entry_value);
				if (rsp.count !== want.count)
					report_mismatch("count", want.count, rsp.count);
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid === 1'b1 && req.ready === 1'b1) ||
			(rsp.valid === 1'b1 && rsp.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		arst_n     = 1'b0;
		req.valid  = 1'b0;
		req.opcode = '0;
		req.key    = '0;
		req.value  = '0;
		rsp.ready  = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_mix(900);
		test_output_hold_off();
		test_full_rate();
		test_random_mix(60);
		req.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

[files.f]
sv/kol_pkg.sv
sv/kol_req_if.sv
sv/kol_rsp_if.sv
sv/kol_cell.sv
sv/kol_cell_array.sv
sv/keyed_ordered_list_unit.sv
sv/kol_checker.sv
bench/tb_top.sv
